@@ hw/rtl/fsgs_pkg.sv @@
// Shared types and constants for the falling sand grid step core.
package fsgs_pkg;

	localparam int KIND_W = 2;
	localparam int ROW_W  = 6;
	localparam int COL_W  = 6;
	localparam int SEED_W = 16;

	localparam logic [KIND_W-1:0] KIND_TOGGLE = 2'd0;
	localparam logic [KIND_W-1:0] KIND_READ   = 2'd1;
	localparam logic [KIND_W-1:0] KIND_TICK   = 2'd2;

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic [ROW_W-1:0]  row;
		logic [COL_W-1:0]  col;
	} req_t;

	typedef struct packed {
		logic accepted;
		logic cell_value;
	} rsp_t;

endpackage

@@ hw/rtl/fsgs_row_mem.sv @@
// Row store of the sand grid: one write port, registered read, per-row valid bits.
module fsgs_row_mem #(
	parameter int DEPTH = 64,
	parameter int WIDTH = 64,
	parameter int AW    = 6
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [DEPTH-1:0] row_valid_q;
	logic [WIDTH-1:0] rd_row_q;
	logic             rd_valid_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rd_row_q <= mem[raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_valid_q <= '0;
			rd_valid_q  <= 1'b0;
		end else begin
			if (we) begin
				row_valid_q[waddr] <= 1'b1;
			end
			if (re) begin
				rd_valid_q <= row_valid_q[raddr];
			end
		end
	end

	// unwritten rows read as empty
	assign rdata = rd_valid_q ? rd_row_q : '0;

endmodule

@@ hw/rtl/falling_sand_grid_step_core.sv @@
// Top level of the falling sand grid step core: sequencer, row scan unit and LFSR.
// Toggle/read: request accepted, row read (S_CRD), result registered (S_CWR), strobed.
// Rejected request: strobed from S_RESP. Tick: one cell per cycle while scanning a row
// (S_TSCAN) by the single column update unit, rows bottom up; S_TFLUSH writes row 0.
// busy is high from acceptance until the result strobe; the receiver cannot stall.
// Reset: grid reads as empty (per-row valid bits cleared), LFSR loaded with 1.
module falling_sand_grid_step_core #(
	parameter int GRID_WIDTH  = 64,
	parameter int GRID_HEIGHT = 64
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  fsgs_pkg::req_t              req,
	output logic                        done,
	output fsgs_pkg::rsp_t              rsp,
	input  logic                        seed_we,
	input  logic [fsgs_pkg::SEED_W-1:0] seed_wdata
);
	import fsgs_pkg::*;

	localparam int AW = (GRID_HEIGHT > 1) ? $clog2(GRID_HEIGHT) : 1;
	localparam int CW = $clog2(GRID_WIDTH);
	localparam logic [AW-1:0] LAST_ROW = AW'(GRID_HEIGHT - 1);
	localparam logic [CW-1:0] LAST_COL = CW'(GRID_WIDTH - 1);

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_CRD    = 3'd1;
	localparam logic [2:0] S_CWR    = 3'd2;
	localparam logic [2:0] S_RESP   = 3'd3;
	localparam logic [2:0] S_TFETCH = 3'd4;
	localparam logic [2:0] S_TCOPY  = 3'd5;
	localparam logic [2:0] S_TSCAN  = 3'd6;
	localparam logic [2:0] S_TFLUSH = 3'd7;

	logic [2:0]            state_q;
	req_t                  req_q;
	logic [AW-1:0]         row_q;
	logic [CW-1:0]         col_q;
	logic [GRID_WIDTH-1:0] cur_q, below_q;
	logic [SEED_W-1:0]     lfsr_q;
	logic                  done_q;
	rsp_t                  rsp_q;

	logic                  mem_re, mem_we;
	logic [AW-1:0]         mem_raddr, mem_waddr;
	logic [GRID_WIDTH-1:0] mem_wdata, mem_rdata;

	logic [GRID_WIDTH-1:0] cur_n, below_n;
	logic [SEED_W-1:0]     lfsr_n;
	logic [CW-1:0]         col_m1, col_p1;
	logic                  left_ok, right_ok, last_col;
	logic                  in_range;
	logic [AW-1:0]         req_row_a;
	logic [CW-1:0]         req_col_c;
	logic                  cell_bit;

	assign in_range  = (32'(req.row) < GRID_HEIGHT) && (32'(req.col) < GRID_WIDTH);
	assign req_row_a = AW'(req_q.row);
	assign req_col_c = CW'(req_q.col);
	assign cell_bit  = mem_rdata[req_col_c];

	assign col_m1   = col_q - 1'b1;
	assign col_p1   = col_q + 1'b1;
	assign last_col = (col_q == LAST_COL);
	assign left_ok  = (col_q != '0) && !below_q[col_m1];
	assign right_ok = !last_col && !below_q[col_p1];

	// one grain move decision per cycle
	always_comb begin
		cur_n   = cur_q;
		below_n = below_q;
		lfsr_n  = lfsr_q;
		if (cur_q[col_q]) begin
			if (!below_q[col_q]) begin
				cur_n[col_q]   = 1'b0;
				below_n[col_q] = 1'b1;
			end else begin
				lfsr_n = {lfsr_q[0] ^ lfsr_q[2] ^ lfsr_q[3] ^ lfsr_q[5], lfsr_q[SEED_W-1:1]};
				if (lfsr_q[0]) begin
					if (right_ok) begin
						cur_n[col_q]   = 1'b0;
						below_n[col_p1] = 1'b1;
					end else if (left_ok) begin
						cur_n[col_q]   = 1'b0;
						below_n[col_m1] = 1'b1;
					end
				end else begin
					if (left_ok) begin
						cur_n[col_q]   = 1'b0;
						below_n[col_m1] = 1'b1;
					end else if (right_ok) begin
						cur_n[col_q]   = 1'b0;
						below_n[col_p1] = 1'b1;
					end
				end
			end
		end
	end

	always_comb begin
		mem_re    = 1'b0;
		mem_raddr = req_row_a;
		mem_we    = 1'b0;
		mem_waddr = req_row_a;
		mem_wdata = mem_rdata;
		unique case (state_q)
			S_CRD: begin
				mem_re = 1'b1;
			end
			S_CWR: begin
				mem_we = (req_q.kind == KIND_TOGGLE);
				mem_wdata[req_col_c] = ~cell_bit;
			end
			S_TFETCH: begin
				mem_re    = 1'b1;
				mem_raddr = row_q;
			end
			S_TSCAN: begin
				mem_we    = last_col && (row_q != LAST_ROW);
				mem_waddr = row_q + 1'b1;
				mem_wdata = below_n;
			end
			S_TFLUSH: begin
				mem_we    = 1'b1;
				mem_waddr = '0;
				mem_wdata = below_q;
			end
			default: begin
			end
		endcase
	end

	fsgs_row_mem #(
		.DEPTH (GRID_HEIGHT),
		.WIDTH (GRID_WIDTH),
		.AW    (AW)
	) u_mem (
		.clk    (clk),
		.arst_n (arst_n),
		.re     (mem_re),
		.raddr  (mem_raddr),
		.we     (mem_we),
		.waddr  (mem_waddr),
		.wdata  (mem_wdata),
		.rdata  (mem_rdata)
	);

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					req_q   <= req;
					below_q <= '1;
					row_q   <= LAST_ROW;
				end
				rsp_q <= '0;
			end
			S_CWR: begin
				rsp_q.accepted   <= 1'b1;
				rsp_q.cell_value <= (req_q.kind == KIND_TOGGLE) ? ~cell_bit : cell_bit;
			end
			S_TCOPY: begin
				cur_q <= mem_rdata;
				col_q <= '0;
			end
			S_TSCAN: begin
				if (last_col) begin
					below_q <= cur_n;
					row_q   <= row_q - 1'b1;
				end else begin
					cur_q   <= cur_n;
					below_q <= below_n;
					col_q   <= col_p1;
				end
			end
			S_TFLUSH: begin
				rsp_q.accepted <= 1'b1;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			done_q  <= 1'b0;
			lfsr_q  <= SEED_W'(1);
		end else begin
			done_q <= 1'b0;
			if (seed_we) begin
				lfsr_q <= (seed_wdata == '0) ? SEED_W'(1) : seed_wdata;
			end else if (state_q == S_TSCAN) begin
				lfsr_q <= lfsr_n;
			end
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						if (req.kind == KIND_TICK) begin
							state_q <= S_TFETCH;
						end else if ((req.kind == KIND_TOGGLE || req.kind == KIND_READ)
								&& in_range) begin
							state_q <= S_CRD;
						end else begin
							state_q <= S_RESP;
						end
					end
				end
				S_CRD: begin
					state_q <= S_CWR;
				end
				S_CWR, S_RESP, S_TFLUSH: begin
					done_q  <= 1'b1;
					state_q <= S_IDLE;
				end
				S_TFETCH: begin
					state_q <= S_TCOPY;
				end
				S_TCOPY: begin
					state_q <= S_TSCAN;
				end
				S_TSCAN: begin
					if (last_col) begin
						state_q <= (row_q == '0) ? S_TFLUSH : S_TFETCH;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign busy = (state_q != S_IDLE);
	assign done = done_q;
	assign rsp  = rsp_q;

endmodule

@@ tb/falling_sand_grid_step_core_test.sv @@
// Self-checking testbench for the falling sand grid step core: toggles, reads and generations.
module falling_sand_grid_step_core_test;
	timeunit 1ns;
	timeprecision 1ps;

	import fsgs_pkg::*;

	localparam int GRID_W = 64;
	localparam int GRID_H = 64;
	localparam int STALL_LIMIT = 20000;
	localparam int RANDOM_ITEMS = 100;
	localparam int PHASES = 5;
	localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

	typedef struct {
		req_t r;
		bit   typed;
		rsp_t want;
	} stim_row_t;

	logic              clk = 1'b0;
	logic              arst_n;
	logic              start;
	logic              busy;
	req_t              req;
	logic              done;
	rsp_t              rsp;
	logic              seed_we;
	logic [SEED_W-1:0] seed_wdata;

	falling_sand_grid_step_core #(
		.GRID_WIDTH (GRID_W),
		.GRID_HEIGHT(GRID_H)
	) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.req       (req),
		.done      (done),
		.rsp       (rsp),
		.seed_we   (seed_we),
		.seed_wdata(seed_wdata)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	bit [GRID_W-1:0] sand_grid [GRID_H];
	bit [SEED_W-1:0] noise_lfsr;
	rsp_t            pending_rsp [$];
	stim_row_t       directed_q [$];
	rsp_t            want;
	int              fail_cnt;
	int              idle_gap;
	bit              quiet;
	int              n_toggle, n_read, n_tick, n_unused, n_seed;

	function automatic req_t make_req(logic [KIND_W-1:0] k, int r, int c);
		req_t q;
		q.kind = k;
		q.row  = r[ROW_W-1:0];
		q.col  = c[COL_W-1:0];
		return q;
	endfunction

	function automatic stim_row_t stim_row(logic [KIND_W-1:0] k, int r, int c,
			bit typed, logic acc, logic val);
		stim_row_t s;
		s.r = make_req(k, r, c);
		s.typed = typed;
		s.want.accepted = acc;
		s.want.cell_value = val;
		return s;
	endfunction

	function automatic bit cell_open(int r, int c);
		if (r < 0 || r >= GRID_H || c < 0 || c >= GRID_W)
			return 1'b0;
		return !sand_grid[r][c];
	endfunction

	function automatic bit lfsr_step();
		bit b;
		bit f;
		b = noise_lfsr[0];
		f = noise_lfsr[0] ^ noise_lfsr[2] ^ noise_lfsr[3] ^ noise_lfsr[5];
		noise_lfsr = {f, noise_lfsr[SEED_W-1:1]};
		return b;
	endfunction

	function automatic void advance_generation();
		int first;
		int second;
		for (int r = GRID_H - 1; r >= 0; r--) begin
			for (int c = 0; c < GRID_W; c++) begin
				if (!sand_grid[r][c])
					continue;
				if (cell_open(r + 1, c)) begin
					sand_grid[r][c] = 1'b0;
					sand_grid[r + 1][c] = 1'b1;
					continue;
				end
				if (lfsr_step()) begin
					first = c + 1;
					second = c - 1;
				end else begin
					first = c - 1;
					second = c + 1;
				end
				if (cell_open(r + 1, first)) begin
					sand_grid[r][c] = 1'b0;
					sand_grid[r + 1][first] = 1'b1;
				end else if (cell_open(r + 1, second)) begin
					sand_grid[r][c] = 1'b0;
					sand_grid[r + 1][second] = 1'b1;
				end
			end
		end
	endfunction

	function automatic rsp_t predict_rsp(req_t q);
		rsp_t p;
		p = '0;
		if (q.kind == KIND_TICK) begin
			advance_generation();
			p.accepted = 1'b1;
		end else if ((q.kind == KIND_TOGGLE || q.kind == KIND_READ) &&
				int'(q.row) < GRID_H && int'(q.col) < GRID_W) begin
			if (q.kind == KIND_TOGGLE)
				sand_grid[q.row][q.col] = !sand_grid[q.row][q.col];
			p.accepted = 1'b1;
			p.cell_value = sand_grid[q.row][q.col];
		end
		return p;
	endfunction

	// request handshake; start stays high across back-to-back requests
	task automatic issue(input req_t q, input bit typed = 1'b0, input rsp_t typed_rsp = '0);
		rsp_t p;
		if (idle_gap != 0) begin
			repeat (idle_gap) @(posedge clk);
			start <= 1'b1;
		end else if (!start) begin
			start <= 1'b1;
		end
		req <= q;
		do @(posedge clk); while (busy);
		p = predict_rsp(q);
		pending_rsp.push_back(typed ? typed_rsp : p);
		case (q.kind)
			KIND_TOGGLE: n_toggle++;
			KIND_READ:   n_read++;
			KIND_TICK:   n_tick++;
			default:     n_unused++;
		endcase
		idle_gap = quiet ? 0 : $urandom_range(0, 9);
		if (idle_gap != 0)
			start <= 1'b0;
	endtask

	task automatic drain();
		if (idle_gap == 0)
			start <= 1'b0;
		while (pending_rsp.size() != 0)
			@(posedge clk);
		@(posedge clk);
	endtask

	task automatic load_seed(input logic [SEED_W-1:0] v);
		drain();
		seed_we <= 1'b1;
		seed_wdata <= v;
		@(posedge clk);
		seed_we <= 1'b0;
		noise_lfsr = (v != '0) ? v : 16'd1;
		n_seed++;
	endtask

	always @(posedge clk) begin
		if (arst_n && done) begin
			if (pending_rsp.size() == 0) begin
				$error("result strobe with no request outstanding");
				fail_cnt++;
			end else begin
				want = pending_rsp.pop_front();
				if (rsp.accepted !== want.accepted) begin
					$error("accepted: expected %0b, got %0b", want.accepted, rsp.accepted);
					fail_cnt++;
				end
				if (rsp.cell_value !== want.cell_value) begin
					$error("cell_value: expected %0b, got %0b",
						want.cell_value, rsp.cell_value);
					fail_cnt++;
				end
			end
		end
	end

	initial begin
		int stall_cycles;
		stall_cycles = 0;
		while (stall_cycles < STALL_LIMIT) begin
			@(posedge clk);
			if ((start && !busy) || done)
				stall_cycles = 0;
			else
				stall_cycles++;
		end
		$display("Simulation FAILED");
		$finish;
	end

	initial begin
		logic [SEED_W-1:0] seeds [PHASES];
		int target;
		int r_lo;
		int c_lo;
		int n;
		int items_before;
		int items_done;

		arst_n = 1'b0;
		start = 1'b0;
		req = '0;
		seed_we = 1'b0;
		seed_wdata = '0;
		foreach (sand_grid[i])
			sand_grid[i] = '0;
		noise_lfsr = 16'd1;
		idle_gap = 0;
		quiet = 1'b0;

		// empty grid, corners, unused kind, edge grains and a blocked stack
		directed_q.push_back(stim_row(KIND_READ,    0,  0, 1, 1, 0));
		directed_q.push_back(stim_row(KIND_READ,   63, 63, 1, 1, 0));
		directed_q.push_back(stim_row(KIND_TOGGLE, 63, 63, 1, 1, 1));
		directed_q.push_back(stim_row(KIND_TOGGLE, 63, 63, 1, 1, 0));
		directed_q.push_back(stim_row(KIND_UNUSED, 63, 63, 1, 0, 0));
		directed_q.push_back(stim_row(KIND_UNUSED,  0,  0, 1, 0, 0));
		directed_q.push_back(stim_row(KIND_TICK,    0,  0, 1, 1, 0));
		directed_q.push_back(stim_row(KIND_TOGGLE,  0,  0, 1, 1, 1));
		directed_q.push_back(stim_row(KIND_TICK,   63, 63, 1, 1, 0));
		directed_q.push_back(stim_row(KIND_READ,    1,  0, 0, 0, 0));
		directed_q.push_back(stim_row(KIND_TOGGLE, 63,  0, 1, 1, 1));
		directed_q.push_back(stim_row(KIND_TOGGLE, 62,  0, 1, 1, 1));
		directed_q.push_back(stim_row(KIND_TOGGLE, 63, 63, 1, 1, 1));
		directed_q.push_back(stim_row(KIND_TOGGLE, 62, 63, 1, 1, 1));
		directed_q.push_back(stim_row(KIND_TOGGLE, 63, 31, 1, 1, 1));
		directed_q.push_back(stim_row(KIND_TOGGLE, 63, 32, 1, 1, 1));
		directed_q.push_back(stim_row(KIND_TOGGLE, 63, 33, 1, 1, 1));
		directed_q.push_back(stim_row(KIND_TOGGLE, 62, 32, 1, 1, 1));
		directed_q.push_back(stim_row(KIND_TOGGLE, 61, 32, 1, 1, 1));
		directed_q.push_back(stim_row(KIND_TICK,   31, 17, 1, 1, 0));
		directed_q.push_back(stim_row(KIND_READ,   63,  1, 0, 0, 0));
		directed_q.push_back(stim_row(KIND_READ,   62, 62, 0, 0, 0));
		directed_q.push_back(stim_row(KIND_READ,   62, 31, 0, 0, 0));
		directed_q.push_back(stim_row(KIND_READ,   62, 33, 0, 0, 0));

		seeds[0] = 16'd0;
		seeds[1] = 16'hFFFF;
		seeds[2] = 16'h8000;
		seeds[3] = 16'($urandom_range(1, 65535));
		seeds[4] = 16'd1;

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_q[i])
			issue(directed_q[i].r, directed_q[i].typed, directed_q[i].want);

		items_before = n_toggle + n_read + n_tick;
		for (int p = 0; p < PHASES; p++) begin
			load_seed(seeds[p]);
			quiet = (p == 2);
			idle_gap = quiet ? 0 : idle_gap;
			target = RANDOM_ITEMS * (p + 1) / PHASES;
			items_done = n_toggle + n_read + n_tick - items_before;
			while (items_done < target) begin
				if ($urandom_range(0, 3) != 0) begin
					// cluster of grains, a few generations, then look at the pile
					r_lo = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 58) : 58;
					case ($urandom_range(0, 2))
						0:       c_lo = 0;
						1:       c_lo = GRID_W - 4;
						default: c_lo = $urandom_range(0, GRID_W - 4);
					endcase
					n = $urandom_range(3, 8);
					repeat (n)
						issue(make_req(KIND_TOGGLE, r_lo + $urandom_range(0, 5),
							c_lo + $urandom_range(0, 3)));
					n = $urandom_range(1, 3);
					repeat (n)
						issue(make_req(KIND_TICK, $urandom_range(0, 63),
							$urandom_range(0, 63)));
					n = $urandom_range(2, 5);
					repeat (n)
						issue(make_req(KIND_READ, r_lo + $urandom_range(0, 5),
							c_lo + $urandom_range(0, 3)));
				end else begin
					n = $urandom_range(2, 5);
					repeat (n)
						issue(make_req(KIND_W'($urandom_range(0, 3)),
							$urandom_range(0, 63), $urandom_range(0, 63)));
				end
				if (p == 3)
					drain();
				items_done = n_toggle + n_read + n_tick - items_before;
			end
		end

		drain();
		repeat (8) @(posedge clk);

		$display("Covered %0d toggles, %0d reads, %0d generations and %0d unused-kind requests",
			n_toggle, n_read, n_tick, n_unused);
		$display("Seed register loaded %0d times, zero and all-ones among the values", n_seed);
		if (fail_cnt == 0 && pending_rsp.size() == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
